// File: design/mdvs_pkg.sv
// Package for the damped Verlet Maxwell step unit: codes and saturation helpers.
// Used by the top level and its checker; depends on nothing.
package mdvs_pkg;

	typedef enum logic [1:0] {
		FUNC_LOAD  = 2'd0,
		FUNC_START = 2'd1,
		FUNC_TICK  = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		REG_STIFF_HIGH  = 3'd0,
		REG_INV_STIFF   = 3'd1,
		REG_DAMP_DT     = 3'd2,
		REG_DT2_MASS    = 3'd3,
		REG_DT2_HALF    = 3'd4,
		REG_ELEM_COUNT  = 3'd5
	} reg_idx_t;

	localparam int MulAW = 36;
	localparam int MulBW = 31;
	localparam int MulRW = 52;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > 64'sd2147483647)
			r = 32'sh7fffffff;
		else if (x < -64'sd2147483648)
			r = 32'sh80000000;
		else
			r = x[31:0];
		return r;
	endfunction

	function automatic logic sat_clip(input logic signed [63:0] x);
		return (x > 64'sd2147483647) || (x < -64'sd2147483648);
	endfunction

endpackage

// File: design/maxwell_damped_verlet_step_unit.sv
// Top level of the damped Verlet Maxwell step unit: sequencer, state and APB registers.
// Depends on mdvs_pkg, mdvs_ram and mdvs_mul.
//
// channel   direction  handshake                      payload
// item      in         start & !busy                  func, element_index, coef_rate,
//                                                     coef_stiff, load_value, preload_mode
// result    out        result_valid, one cycle        displacement, total_force, saturated
// config    in         psel & penable & pwrite        paddr, pwdata (prdata on read)
//
// Load: no result. Start: states SV and SK, result strobed as the unit returns to idle.
// Tick: states RD to AC per active element, then FM to FIN, on the shared multiplier.
// Element displacements reset through valid bits, so no clearing pass is needed.
// The receiver cannot stall; results are never held back.
module maxwell_damped_verlet_step_unit #(
	parameter int NUM_ELEMENTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [2:0]  element_index,
	input  logic [15:0] coef_rate,
	input  logic [15:0] coef_stiff,
	input  logic signed [31:0] load_value,
	input  logic        preload_mode,
	output logic        result_valid,
	output logic signed [31:0] displacement,
	output logic signed [31:0] total_force,
	output logic        saturated,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mdvs_pkg::*;

	localparam int AW = NUM_ELEMENTS > 1 ? $clog2(NUM_ELEMENTS) : 1;
	localparam int CW = $clog2(NUM_ELEMENTS + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_SV, ST_SK, ST_RD, ST_D1, ST_D2, ST_UP, ST_WF, ST_AC,
		ST_FM, ST_GS, ST_NET, ST_DMP, ST_FIN
	} state_t;

	state_t state_q;

	logic [30:0] stiff_q, inv_q, dt2m_q, dt2h_q;
	logic [15:0] damp_q;
	logic [3:0]  count_q;

	logic signed [31:0] g_q, gp_q, fill_q, af_q, u_q, total_q, load_q;
	logic               mode_q;
	logic signed [MulRW-1:0] d1_q, acc_q;
	logic signed [59:0] wsum_q;
	logic [NUM_ELEMENTS-1:0] vld_q;
	logic [CW-1:0] i_q, n_c;
	logic clip_q;

	logic signed [MulAW-1:0] mul_a;
	logic        [MulBW-1:0] mul_b;
	logic signed [MulRW-1:0] m_q;

	logic        rf_we, disp_we;
	logic [31:0] rf_rd, disp_rd;
	logic signed [31:0] u_c, new_u, ws_c, fm_c, tot_c, net_c, kick_c, next_c;
	logic signed [MulRW:0] hs_c;
	logic accept;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign pready = 1'b1;

	assign rf_we = accept && (func == FUNC_LOAD) && (32'(element_index) < NUM_ELEMENTS);

	mdvs_ram #(.WIDTH(32), .DEPTH(NUM_ELEMENTS)) u_rf_ram (
		.clk(clk), .we(rf_we), .waddr(AW'(element_index)),
		.wdata({coef_rate, coef_stiff}), .raddr(i_q[AW-1:0]), .rdata(rf_rd)
	);

	assign disp_we = (state_q == ST_UP);

	mdvs_ram #(.WIDTH(32), .DEPTH(NUM_ELEMENTS)) u_disp_ram (
		.clk(clk), .we(disp_we), .waddr(i_q[AW-1:0]),
		.wdata(new_u), .raddr(i_q[AW-1:0]), .rdata(disp_rd)
	);

	mdvs_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .m_q(m_q));

	always_comb begin
		if (32'(count_q) > NUM_ELEMENTS)
			n_c = CW'(NUM_ELEMENTS);
		else
			n_c = CW'(count_q);
		u_c    = vld_q[i_q[AW-1:0]] ? $signed(disp_rd) : fill_q;
		hs_c   = ((MulRW+1)'(d1_q) + (MulRW+1)'(m_q) + (MulRW+1)'(1)) >>> 1;
		new_u  = sat32(64'(u_q) + 64'(hs_c));
		ws_c   = sat32(64'(wsum_q));
		fm_c   = sat32(64'(m_q));
		tot_c  = sat32(64'(af_q) + 64'(fm_c));
		net_c  = sat32(64'(total_q) - 64'(m_q));
		kick_c = sat32(64'(m_q));
		next_c = sat32(64'(g_q) + 64'(g_q) - 64'(gp_q) - 64'(m_q) + 64'(acc_q));
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_IDLE: begin
				mul_a = MulAW'(load_value);
				mul_b = inv_q;
			end
			ST_SV: begin
				mul_a = MulAW'(load_q);
				mul_b = dt2h_q;
			end
			ST_D1: begin
				mul_a = MulAW'(g_q) - MulAW'(u_c);
				mul_b = {15'd0, rf_rd[31:16]};
			end
			ST_D2: begin
				mul_a = MulAW'(g_q) - (MulAW'(u_q) + m_q[MulAW-1:0]);
				mul_b = {15'd0, rf_rd[31:16]};
			end
			ST_WF: begin
				mul_a = MulAW'(u_q);
				mul_b = {15'd0, rf_rd[15:0]};
			end
			ST_FM: begin
				mul_a = MulAW'(ws_c);
				mul_b = stiff_q;
			end
			ST_GS: begin
				mul_a = MulAW'(g_q);
				mul_b = stiff_q;
			end
			ST_NET: begin
				mul_a = MulAW'(net_c);
				mul_b = dt2m_q;
			end
			ST_DMP: begin
				mul_a = MulAW'(g_q) - MulAW'(gp_q);
				mul_b = {15'd0, damp_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiff_q <= 31'd65536;
			inv_q   <= 31'd65536;
			damp_q  <= '0;
			dt2m_q  <= '0;
			dt2h_q  <= '0;
			count_q <= 4'd8;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[4:2])
				REG_STIFF_HIGH: stiff_q <= pwdata[30:0];
				REG_INV_STIFF:  inv_q   <= pwdata[30:0];
				REG_DAMP_DT:    damp_q  <= pwdata[15:0];
				REG_DT2_MASS:   dt2m_q  <= pwdata[30:0];
				REG_DT2_HALF:   dt2h_q  <= pwdata[30:0];
				REG_ELEM_COUNT: count_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_STIFF_HIGH: prdata = {1'b0, stiff_q};
			REG_INV_STIFF:  prdata = {1'b0, inv_q};
			REG_DAMP_DT:    prdata = {16'd0, damp_q};
			REG_DT2_MASS:   prdata = {1'b0, dt2m_q};
			REG_DT2_HALF:   prdata = {1'b0, dt2h_q};
			REG_ELEM_COUNT: prdata = {28'd0, count_q};
			default:        prdata = '0;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			result_valid <= 1'b0;
			displacement <= '0;
			total_force  <= '0;
			saturated    <= 1'b0;
			vld_q        <= '0;
			g_q          <= '0;
			gp_q         <= '0;
			fill_q       <= '0;
			af_q         <= '0;
			u_q          <= '0;
			total_q      <= '0;
			load_q       <= '0;
			mode_q       <= 1'b0;
			d1_q         <= '0;
			acc_q        <= '0;
			wsum_q       <= '0;
			i_q          <= '0;
			clip_q       <= 1'b0;
		end else begin
			result_valid <= (state_q == ST_SK) || (state_q == ST_FIN);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						load_q <= load_value;
						mode_q <= preload_mode;
						clip_q <= 1'b0;
						i_q    <= '0;
						wsum_q <= '0;
						case (func)
							FUNC_START: state_q <= ST_SV;
							FUNC_TICK:  state_q <= (n_c == '0) ? ST_FM : ST_RD;
							default:    state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SV: begin
					vld_q <= '0;
					if (mode_q) begin
						g_q    <= sat32(64'(m_q));
						gp_q   <= sat32(64'(m_q));
						fill_q <= sat32(64'(m_q));
						af_q   <= '0;
						clip_q <= sat_clip(64'(m_q));
					end else begin
						g_q    <= '0;
						gp_q   <= '0;
						fill_q <= '0;
						af_q   <= load_q;
					end
					state_q <= ST_SK;
				end
				ST_SK: begin
					displacement <= g_q;
					total_force  <= af_q;
					saturated    <= clip_q || sat_clip(64'(m_q))
						|| sat_clip(64'(g_q) + 64'(kick_c));
					g_q          <= sat32(64'(g_q) + 64'(kick_c));
					state_q      <= ST_IDLE;
				end
				ST_RD: state_q <= ST_D1;
				ST_D1: begin
					u_q     <= u_c;
					state_q <= ST_D2;
				end
				ST_D2: begin
					d1_q    <= m_q;
					state_q <= ST_UP;
				end
				ST_UP: begin
					u_q                <= new_u;
					vld_q[i_q[AW-1:0]] <= 1'b1;
					clip_q             <= clip_q || sat_clip(64'(u_q) + 64'(hs_c));
					state_q            <= ST_WF;
				end
				ST_WF: state_q <= ST_AC;
				ST_AC: begin
					wsum_q <= wsum_q + 60'(m_q);
					i_q    <= i_q + CW'(1);
					state_q <= (i_q + CW'(1) < n_c) ? ST_RD : ST_FM;
				end
				ST_FM: begin
					clip_q  <= clip_q || sat_clip(64'(wsum_q));
					state_q <= ST_GS;
				end
				ST_GS: begin
					total_q <= tot_c;
					clip_q  <= clip_q || sat_clip(64'(m_q))
						|| sat_clip(64'(af_q) + 64'(fm_c));
					state_q <= ST_NET;
				end
				ST_NET: begin
					clip_q  <= clip_q || sat_clip(64'(total_q) - 64'(m_q));
					state_q <= ST_DMP;
				end
				ST_DMP: begin
					acc_q   <= m_q;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					displacement <= next_c;
					total_force  <= total_q;
					saturated    <= clip_q || sat_clip(64'(g_q) + 64'(g_q) - 64'(gp_q)
						- 64'(m_q) + 64'(acc_q));
					gp_q         <= g_q;
					g_q          <= next_c;
					state_q      <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: design/mdvs_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module mdvs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// File: design/mdvs_mul.sv
// Shared signed by unsigned multiplier with round-to-nearest Q16 shift, output registered.
// Uses mdvs_pkg for operand widths.
module mdvs_mul (
	input  logic                                  clk,
	input  logic signed [mdvs_pkg::MulAW-1:0]     a,
	input  logic        [mdvs_pkg::MulBW-1:0]     b,
	output logic signed [mdvs_pkg::MulRW-1:0]     m_q
);
	import mdvs_pkg::*;

	logic signed [MulAW+MulBW:0] prod;
	logic signed [MulAW+MulBW:0] rnd;

	always_comb begin
		prod = a * $signed({1'b0, b});
		rnd  = (prod + (MulAW+MulBW+1)'(32768)) >>> 16;
	end

	always_ff @(posedge clk) begin
		m_q <= rnd[MulRW-1:0];
	end
endmodule

// File: design/mdvs_checker.sv
// Port-level checker for the damped Verlet Maxwell step unit, with its bind.
// Depends on mdvs_pkg for the item codes.
module mdvs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] func,
	input logic       result_valid,
	input logic       pready
);
	import mdvs_pkg::*;

	a_beat_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy) else $error("result beat while busy");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("result beat repeated");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == FUNC_LOAD) |=> (!busy && !result_valid))
		else $error("load item not single cycle");

	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (func == FUNC_START || func == FUNC_TICK)) |=> busy)
		else $error("start or tick did not occupy the unit");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pready) else $error("pready low");
endmodule

bind maxwell_damped_verlet_step_unit mdvs_checker u_mdvs_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
	.result_valid(result_valid), .pready(pready)
);

// File: test/mdvs_checker.sv
// Checker for the damped Verlet Maxwell step unit: tracks register writes and item beats,
// predicts each result beat and compares it. Depends on mdvs_pkg.
`timescale 1ns / 100ps
module mdvs_tb_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         func,
	input  logic [2:0]         element_index,
	input  logic [15:0]        coef_rate,
	input  logic [15:0]        coef_stiff,
	input  logic signed [31:0] load_value,
	input  logic               preload_mode,
	input  logic               result_valid,
	input  logic signed [31:0] displacement,
	input  logic signed [31:0] total_force,
	input  logic               saturated,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	output int                 errors,
	output int                 pending,
	output int                 items_seen,
	output int                 results_seen,
	output int                 clipped_seen
);
	import mdvs_pkg::*;

	typedef struct packed {
		logic signed [31:0] disp;
		logic signed [31:0] force_q;
		logic               sat;
	} step_out_t;

	localparam int NElem = 8;

	longint    elem_u[NElem];
	longint    elem_rate[NElem];
	longint    elem_frac[NElem];
	longint    g_disp, g_prev, app_force;
	longint    k_stiff, k_inv, k_damp, k_dt2m, k_kick, k_count;
	bit        clip;
	step_out_t step_q[$];

	function automatic longint mulq(input longint v, input longint c);
		return (v * c + 64'sd32768) >>> 16;
	endfunction

	function automatic longint sat(input longint x);
		if (x > 64'sd2147483647) begin
			clip = 1'b1;
			return 64'sd2147483647;
		end
		if (x < -64'sd2147483648) begin
			clip = 1'b1;
			return -64'sd2147483648;
		end
		return x;
	endfunction

	function automatic bit step_body(input func_t f, input logic [2:0] idx,
			input logic [15:0] cr, input logic [15:0] cs, input logic signed [31:0] lv,
			input logic rm, output step_out_t r);
		longint ld, v, d0, kick, g, gp, u, d1, d2, ws, fm, tot, net, acc, dmp;
		int n;
		ld = longint'(lv);
		clip = 1'b0;
		r = '0;
		case (f)
			FUNC_LOAD: begin
				elem_rate[idx] = longint'(cr);
				elem_frac[idx] = longint'(cs);
				return 1'b0;
			end
			FUNC_START: begin
				if (rm) begin
					v = sat(mulq(ld, k_inv));
					for (int i = 0; i < NElem; i++) elem_u[i] = v;
					g_disp = v;
					g_prev = v;
					app_force = 0;
				end else begin
					for (int i = 0; i < NElem; i++) elem_u[i] = 0;
					g_disp = 0;
					g_prev = 0;
					app_force = ld;
				end
				d0 = g_disp;
				kick = sat(mulq(ld, k_kick));
				g_disp = sat(g_disp + kick);
				r.disp = 32'(d0);
				r.force_q = 32'(app_force);
				r.sat = clip;
				return 1'b1;
			end
			FUNC_TICK: begin
				g = g_disp;
				gp = g_prev;
				n = (k_count > NElem) ? NElem : int'(k_count);
				for (int i = 0; i < n; i++) begin
					u = elem_u[i];
					d1 = mulq(g - u, elem_rate[i]);
					d2 = mulq(g - (u + d1), elem_rate[i]);
					elem_u[i] = sat(u + ((d1 + d2 + 1) >>> 1));
				end
				ws = 0;
				for (int i = 0; i < n; i++) ws += mulq(elem_u[i], elem_frac[i]);
				ws = sat(ws);
				fm = sat(mulq(ws, k_stiff));
				tot = sat(app_force + fm);
				net = sat(tot - mulq(g, k_stiff));
				acc = mulq(net, k_dt2m);
				dmp = mulq(g - gp, k_damp);
				g_prev = g;
				g_disp = sat(2 * g - gp - dmp + acc);
				r.disp = 32'(g_disp);
				r.force_q = 32'(tot);
				r.sat = clip;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		step_out_t r, e;
		if (!arst_n) begin
			for (int i = 0; i < NElem; i++) begin
				elem_u[i] = 0;
				elem_rate[i] = 0;
				elem_frac[i] = 0;
			end
			g_disp = 0;
			g_prev = 0;
			app_force = 0;
			k_stiff = 65536;
			k_inv = 65536;
			k_damp = 0;
			k_dt2m = 0;
			k_kick = 0;
			k_count = 8;
			step_q.delete();
			errors <= 0;
			pending <= 0;
			items_seen <= 0;
			results_seen <= 0;
			clipped_seen <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[4:2]))
					REG_STIFF_HIGH: k_stiff = longint'(pwdata[30:0]);
					REG_INV_STIFF:  k_inv = longint'(pwdata[30:0]);
					REG_DAMP_DT:    k_damp = longint'(pwdata[15:0]);
					REG_DT2_MASS:   k_dt2m = longint'(pwdata[30:0]);
					REG_DT2_HALF:   k_kick = longint'(pwdata[30:0]);
					REG_ELEM_COUNT: k_count = longint'(pwdata[3:0]);
					default: ;
				endcase
			end
			if (result_valid) begin
				results_seen <= results_seen + 1;
				if (saturated) clipped_seen <= clipped_seen + 1;
				if (step_q.size() == 0) begin
					errors <= errors + 1;
					if (errors < 10)
						$display("%0t: unexpected result beat disp=%0d force=%0d",
							$realtime, displacement, total_force);
				end else begin
					e = step_q.pop_front();
					if (e.disp !== displacement || e.force_q !== total_force ||
							e.sat !== saturated) begin
						errors <= errors + 1;
						if (errors < 10)
							$display("%0t: result beat exp disp=%0d force=%0d sat=%0b, got %0d %0d %0b",
								$realtime, e.disp, e.force_q, e.sat,
								displacement, total_force, saturated);
					end
				end
			end
			if (start && !busy) begin
				items_seen <= items_seen + 1;
				if (step_body(func_t'(func), element_index, coef_rate, coef_stiff,
						load_value, preload_mode, r))
					step_q = {step_q, r};
			end
			pending <= step_q.size();
		end
	end

endmodule

// File: test/testbench.sv
// Top of the testbench for maxwell_damped_verlet_step_unit: clock, reset, register writes,
// item stimulus and verdict. Depends on mdvs_pkg, the block and mdvs_tb_checker.
`timescale 1ns / 100ps
module testbench;
	import mdvs_pkg::*;

	logic               clk, arst_n;
	logic               start, busy;
	logic [1:0]         func;
	logic [2:0]         element_index;
	logic [15:0]        coef_rate, coef_stiff;
	logic signed [31:0] load_value;
	logic               preload_mode;
	logic               result_valid;
	logic signed [31:0] displacement, total_force;
	logic               saturated;
	logic               psel, penable, pwrite, pready;
	logic [4:0]         paddr;
	logic [31:0]        pwdata, prdata;
	int                 errors, pending, items_seen, results_seen, clipped_seen;
	int                 quiet_cycles;
	int                 gap_pct;

	maxwell_damped_verlet_step_unit dut (.*);

	mdvs_tb_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((start && !busy) || result_valid || (psel && penable))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= 3000) begin
				$display("maxwell_damped_verlet_step_unit: mismatch");
				$finish;
			end
		end
	end

	task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic send(input func_t f, input logic [2:0] idx, input logic [15:0] cr,
			input logic [15:0] cs, input logic signed [31:0] lv, input logic rm);
		func <= f;
		element_index <= idx;
		coef_rate <= cr;
		coef_stiff <= cs;
		load_value <= lv;
		preload_mode <= rm;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	function automatic logic [31:0] rnd_force();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			2: return 32'($signed($urandom_range(131072)) - 65536);
			default: return 32'($signed($urandom_range(4 << 20)) - (2 << 20));
		endcase
	endfunction

	function automatic logic [15:0] rnd_coef();
		case ($urandom_range(3))
			0: return $urandom_range(1) ? 16'hffff : 16'h0000;
			1: return 16'($urandom);
			default: return 16'($urandom_range(8000));
		endcase
	endfunction

	task automatic set_regs(input int kind);
		case (kind)
			0: begin
				reg_write(REG_STIFF_HIGH, $urandom_range(32768, 262144));
				reg_write(REG_INV_STIFF, $urandom_range(16384, 131072));
				reg_write(REG_DAMP_DT, $urandom_range(8000));
				reg_write(REG_DT2_MASS, $urandom_range(2000));
				reg_write(REG_DT2_HALF, $urandom_range(1000));
				reg_write(REG_ELEM_COUNT, $urandom_range(1, 8));
			end
			1: begin
				reg_write(REG_STIFF_HIGH, 32'h7fffffff);
				reg_write(REG_INV_STIFF, 32'h7fffffff);
				reg_write(REG_DAMP_DT, 32'hffff);
				reg_write(REG_DT2_MASS, 32'h7fffffff);
				reg_write(REG_DT2_HALF, 32'h7fffffff);
				reg_write(REG_ELEM_COUNT, 15);
			end
			2: begin
				reg_write(REG_STIFF_HIGH, 1);
				reg_write(REG_INV_STIFF, 0);
				reg_write(REG_DAMP_DT, 0);
				reg_write(REG_DT2_MASS, 0);
				reg_write(REG_DT2_HALF, 0);
				reg_write(REG_ELEM_COUNT, $urandom_range(1) ? 0 : 1);
			end
			default: begin
				reg_write(REG_STIFF_HIGH, $urandom_range(1, 32'h7fffffff));
				reg_write(REG_INV_STIFF, $urandom & 32'h7fffffff);
				reg_write(REG_DAMP_DT, $urandom & 32'hffff);
				reg_write(REG_DT2_MASS, $urandom & 32'h7fffffff);
				reg_write(REG_DT2_HALF, $urandom & 32'h7fffffff);
				reg_write(REG_ELEM_COUNT, $urandom_range(15));
			end
		endcase
	endtask

	initial begin
		int pick;
		arst_n = 1'b0;
		start = 1'b0;
		func = FUNC_NONE;
		element_index = '0;
		coef_rate = '0;
		coef_stiff = '0;
		load_value = '0;
		preload_mode = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		gap_pct = 33;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every element written before the first tick
		for (int i = 0; i < 8; i++)
			send(FUNC_LOAD, i[2:0], (i % 2) ? 16'hffff : 16'h0000,
				(i < 4) ? 16'hffff : 16'h0000, 32'h0, 1'b0);
		send(FUNC_START, 3'd0, 16'h0, 16'h0, 32'h7fffffff, 1'b0);
		send(FUNC_TICK, 3'd0, 16'h0, 16'h0, 32'h0, 1'b0);
		send(FUNC_START, 3'd7, 16'hffff, 16'hffff, 32'h80000000, 1'b0);
		send(FUNC_TICK, 3'd0, 16'h0, 16'h0, 32'h0, 1'b1);
		send(FUNC_START, 3'd0, 16'h0, 16'h0, 32'h7fffffff, 1'b1);
		send(FUNC_TICK, 3'd0, 16'h0, 16'h0, 32'h0, 1'b0);
		send(FUNC_START, 3'd0, 16'h0, 16'h0, 32'h80000000, 1'b1);
		send(FUNC_TICK, 3'd0, 16'h0, 16'h0, 32'h0, 1'b0);
		send(FUNC_NONE, 3'd5, 16'h1234, 16'h4321, 32'h1, 1'b1);
		send(FUNC_START, 3'd0, 16'h0, 16'h0, 32'h00010000, 1'b0);
		send(FUNC_TICK, 3'd0, 16'h0, 16'h0, 32'h0, 1'b0);
		send(FUNC_LOAD, 3'd3, 16'h8000, 16'h8000, 32'h0, 1'b0);
		send(FUNC_TICK, 3'd0, 16'h0, 16'h0, 32'h0, 1'b0);

		for (int seg = 0; seg < 12; seg++) begin
			gap_pct = (seg < 4) ? 33 : (seg < 8) ? 71 : 0;
			drain();
			set_regs(seg % 4);
			for (int k = 0; k < 45; k++) begin
				pick = $urandom_range(99);
				if (pick < 50)
					send(FUNC_TICK, 3'($urandom), 16'($urandom), 16'($urandom),
						32'($urandom), 1'($urandom));
				else if (pick < 70)
					send(FUNC_START, 3'($urandom), 16'($urandom), 16'($urandom),
						rnd_force(), 1'($urandom));
				else if (pick < 92)
					send(FUNC_LOAD, 3'($urandom), rnd_coef(), rnd_coef(),
						32'($urandom), 1'($urandom));
				else
					send(FUNC_NONE, 3'($urandom), 16'($urandom), 16'($urandom),
						32'($urandom), 1'($urandom));
			end
		end

		drain();
		$display("Covered %0d item beats and %0d result beats (%0d with clipping)",
			items_seen, results_seen, clipped_seen);
		$display("over 12 register settings including both extremes, with varied sender gaps.");
		if (errors == 0)
			$display("maxwell_damped_verlet_step_unit: match");
		else
			$display("maxwell_damped_verlet_step_unit: mismatch");
		$finish;
	end

endmodule
